@@ hdl/load_cell_fill_to_weight_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the fill-to-weight controller
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_FILL_TO_WEIGHT_CONTROLLER_DEFINES_SVH
`define LOAD_CELL_FILL_TO_WEIGHT_CONTROLLER_DEFINES_SVH

// The property holds at every clock edge outside reset.
`define LCFW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the condition holds, the consequence holds in the following cycle.
`define LCFW_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lcfw_pkg.sv @@
// ----------------------------------------------------------------------------
// lcfw_pkg
// Types, constants and codes shared by the fill-to-weight controller.
// ----------------------------------------------------------------------------
package lcfw_pkg;

  localparam int unsigned TICKS_PER_MS = 1000;
  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned PRESC_W      = 10;
  localparam int unsigned PULSE_W      = 5;
  localparam int unsigned ELAPSED_W    = 17;
  localparam int unsigned MS_W         = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 24;

  localparam logic [PRESC_W:0]   TICKS_LIMIT = (PRESC_W+1)'(TICKS_PER_MS);
  localparam logic [PULSE_W-1:0] DATA_PULSES = PULSE_W'(SAMPLE_BITS);
  localparam logic [PULSE_W-1:0] LAST_PULSE  = PULSE_W'(SAMPLE_BITS + 1);

  localparam logic [SAMPLE_BITS-1:0] TARGET_RESET  = SAMPLE_BITS'(50);
  localparam logic [MS_W-1:0]        PERIOD_RESET  = MS_W'(500);
  localparam logic [MS_W-1:0]        TIMEOUT_RESET = MS_W'(30000);

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_FIRST_WAIT,
    MODE_FIRST_SHIFT,
    MODE_DELAY,
    MODE_LOOP_WAIT,
    MODE_LOOP_SHIFT,
    MODE_REACHED,
    MODE_TIMEDOUT
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_IDLE,
    STATUS_BUSY,
    STATUS_REACHED,
    STATUS_TIMEDOUT
  } status_e;

  typedef struct packed {
    logic start_req;
    logic data_pin;
  } in_t;

  typedef struct packed {
    logic                           serial_clock;
    logic                           lid_open;
    logic signed [SAMPLE_BITS-1:0]  weight;
    logic                           sample_valid;
    logic                           stable;
    logic [1:0]                     status;
  } out_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] target_weight;
    logic [MS_W-1:0]               sample_period_ms;
    logic [MS_W-1:0]               timeout_ms;
  } cfg_t;

endpackage

@@ hdl/lcfw_core.sv @@
// ----------------------------------------------------------------------------
// lcfw_core
// Per-tick sequencer: serial converter read, sample timer and fill decision.
// ----------------------------------------------------------------------------
`include "load_cell_fill_to_weight_controller_defines.svh"

module lcfw_core import lcfw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  in_i,
  input  cfg_t cfg_i,
  output out_t res_o
);

  mode_e                  mode_q, mode_d;
  logic [SAMPLE_BITS-1:0] shift_q, shift_d;
  logic [PULSE_W-1:0]     pulse_q, pulse_d;
  logic                   phase_q, phase_d;
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [SAMPLE_BITS-1:0] cur_q, cur_d;
  logic [PRESC_W-1:0]     presc_q, presc_d;
  logic [ELAPSED_W-1:0]   elapsed_q, elapsed_d;
  logic [MS_W-1:0]        wait_q, wait_d;

  logic                   counting;
  logic                   ms_event;
  logic [PULSE_W-1:0]     pulse_inc;
  logic [SAMPLE_BITS-1:0] shift_nxt;
  logic                   read_done;
  logic [MS_W-1:0]        wait_nxt;
  logic                   loop_done;

  assign counting  = (mode_q == MODE_DELAY) || (mode_q == MODE_LOOP_WAIT) ||
                     (mode_q == MODE_LOOP_SHIFT);
  assign ms_event  = counting && (({1'b0, presc_q} + 1'b1) >= TICKS_LIMIT);
  assign pulse_inc = pulse_q + 1'b1;
  assign shift_nxt = (pulse_q < DATA_PULSES) ?
                     {shift_q[SAMPLE_BITS-2:0], in_i.data_pin} : shift_q;
  assign read_done = phase_q && (pulse_inc >= LAST_PULSE);
  assign wait_nxt  = (ms_event && (wait_q != '1)) ? wait_q + 1'b1 : wait_q;

  always_comb begin
    mode_d    = mode_q;
    shift_d   = shift_q;
    pulse_d   = pulse_q;
    phase_d   = phase_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    presc_d   = presc_q;
    elapsed_d = elapsed_q;
    wait_d    = wait_q;
    loop_done = 1'b0;

    if (counting) begin
      presc_d = ms_event ? '0 : presc_q + 1'b1;
      if (ms_event && (elapsed_q != '1)) begin
        elapsed_d = elapsed_q + 1'b1;
      end
    end

    unique case (mode_q)
      MODE_IDLE, MODE_REACHED, MODE_TIMEDOUT: begin
        if (in_i.start_req) begin
          mode_d  = MODE_FIRST_WAIT;
          phase_d = 1'b0;
        end
      end
      MODE_FIRST_WAIT, MODE_LOOP_WAIT: begin
        if (!in_i.data_pin) begin
          phase_d = 1'b1;
          pulse_d = '0;
          shift_d = '0;
          mode_d  = (mode_q == MODE_FIRST_WAIT) ? MODE_FIRST_SHIFT : MODE_LOOP_SHIFT;
        end
      end
      MODE_FIRST_SHIFT: begin
        if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          shift_d = shift_nxt;
          pulse_d = pulse_inc;
        end
        if (read_done) begin
          cur_d     = shift_nxt;
          prev_d    = shift_nxt;
          presc_d   = '0;
          elapsed_d = '0;
          wait_d    = '0;
          if ($signed(shift_nxt) >= cfg_i.target_weight) begin
            mode_d = MODE_REACHED;
          end else begin
            mode_d = MODE_DELAY;
          end
        end
      end
      MODE_DELAY: begin
        wait_d = wait_nxt;
        if (wait_nxt >= cfg_i.sample_period_ms) begin
          mode_d = MODE_LOOP_WAIT;
        end
      end
      MODE_LOOP_SHIFT: begin
        if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          shift_d = shift_nxt;
          pulse_d = pulse_inc;
        end
        if (read_done) begin
          loop_done = 1'b1;
          cur_d     = shift_nxt;
          prev_d    = shift_nxt;
          if (elapsed_d > {1'b0, cfg_i.timeout_ms}) begin
            mode_d = MODE_TIMEDOUT;
          end else if ($signed(shift_nxt) >= cfg_i.target_weight) begin
            mode_d = MODE_REACHED;
          end else begin
            wait_d = '0;
            mode_d = MODE_DELAY;
          end
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.serial_clock = phase_d;
    res_o.lid_open     = (mode_d == MODE_DELAY) || (mode_d == MODE_LOOP_WAIT) ||
                         (mode_d == MODE_LOOP_SHIFT);
    res_o.weight       = $signed(cur_d);
    res_o.sample_valid = loop_done;
    res_o.stable       = loop_done && ($signed(cur_d) <= $signed(prev_q));
    unique case (mode_d)
      MODE_IDLE:     res_o.status = STATUS_IDLE;
      MODE_REACHED:  res_o.status = STATUS_REACHED;
      MODE_TIMEDOUT: res_o.status = STATUS_TIMEDOUT;
      default:       res_o.status = STATUS_BUSY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      shift_q   <= '0;
      pulse_q   <= '0;
      phase_q   <= 1'b0;
      prev_q    <= '0;
      cur_q     <= '0;
      presc_q   <= '0;
      elapsed_q <= '0;
      wait_q    <= '0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      shift_q   <= shift_d;
      pulse_q   <= pulse_d;
      phase_q   <= phase_d;
      prev_q    <= prev_d;
      cur_q     <= cur_d;
      presc_q   <= presc_d;
      elapsed_q <= elapsed_d;
      wait_q    <= wait_d;
    end
  end

  `LCFW_ASSERT(a_stable_needs_sample, !res_o.stable || res_o.sample_valid, "stable without sample")
  `LCFW_ASSERT(a_pulse_bound, pulse_q <= LAST_PULSE, "pulse count past the extra pulse")
  `LCFW_ASSERT_NEXT(a_idle_holds, step_i && (mode_q == MODE_IDLE) && !in_i.start_req, mode_q == MODE_IDLE, "left idle without a start")

endmodule

@@ hdl/lcfw_outbuf.sv @@
// ----------------------------------------------------------------------------
// lcfw_outbuf
// Result register with a skid stage, so a tick is taken while a result waits.
// ----------------------------------------------------------------------------
`include "load_cell_fill_to_weight_controller_defines.svh"

module lcfw_outbuf import lcfw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  out_t out_q, out_d;
  out_t skid_q, skid_d;
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  logic take;

  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!out_valid_q || take) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LCFW_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid holds a result ahead of the output")
  `LCFW_ASSERT_NEXT(a_push_lands, push_i, out_valid_q, "pushed result not held")

endmodule

@@ hdl/load_cell_fill_to_weight_controller.sv @@
// A tick's result is registered in the result register, or in the skid stage while the output stalls.
// Throughput: one tick per cycle while the skid stage is not full; the state update is a single registered pass.
// A result register with a skid stage lets ticks flow while one result waits.
// Reset: asynchronous; the sequencer returns to idle with all counters and
// weights at zero, and the registers load target 50, period 500, timeout 30000.
// ----------------------------------------------------------------------------
// load_cell_fill_to_weight_controller
// Fill-to-weight controller reading a 24-bit serial load-cell converter.
// ----------------------------------------------------------------------------
module load_cell_fill_to_weight_controller import lcfw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  out_t res;
  logic accept;
  logic full;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !full;
  assign in_stall_o  = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_weight    <= $signed(TARGET_RESET);
      cfg_q.sample_period_ms <= PERIOD_RESET;
      cfg_q.timeout_ms       <= TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TARGET:  cfg_q.target_weight    <= $signed(cfg_data_i[SAMPLE_BITS-1:0]);
        CFG_PERIOD:  cfg_q.sample_period_ms <= cfg_data_i[MS_W-1:0];
        CFG_TIMEOUT: cfg_q.timeout_ms       <= cfg_data_i[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lcfw_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .in_i   (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  lcfw_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/load_cell_fill_to_weight_controller_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// load_cell_fill_to_weight_controller_tb
// Self-checking bench for the fill-to-weight controller. Each tick the block
// takes is also run through a behavioral model of the sequencer kept in this
// bench, and every result the block returns is compared field by field with
// the oldest prediction. Directed fills cover register extremes, a data line
// held high, timeouts, a zero sample period, retargeting while dispensing and
// a long output hold-off. Random fills with random pacing on both sides follow.
// ----------------------------------------------------------------------------
module load_cell_fill_to_weight_controller_tb;
  import lcfw_pkg::*;

  localparam int unsigned MAX_CYCLES      = 3_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam longint      WEIGHT_MIN      = -8388608;
  localparam longint      WEIGHT_MAX      = 8388607;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mode_e                         scale_mode;
  logic [SAMPLE_BITS-1:0]        shift_acc;
  logic [SAMPLE_BITS-1:0]        last_weight;
  logic [SAMPLE_BITS-1:0]        prior_weight;
  logic [PULSE_W-1:0]            pulse_cnt;
  logic                          sclk_phase;
  logic [PRESC_W-1:0]            ms_presc;
  logic [ELAPSED_W-1:0]          elapsed_ms;
  logic [MS_W-1:0]               waited_ms;
  logic signed [SAMPLE_BITS-1:0] tgt_weight;
  logic [MS_W-1:0]               period_ms;
  logic [MS_W-1:0]               abort_ms;

  out_t        pending_readings[$];
  int unsigned mismatches;
  int unsigned weighings;
  int unsigned live_ticks;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          gaps_on;
  bit          hold_off_req;
  int unsigned hold_left;
  int unsigned stall_seg;
  int unsigned stall_pct;

  load_cell_fill_to_weight_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic lid_phase(input mode_e m);
    return m == MODE_DELAY || m == MODE_LOOP_WAIT || m == MODE_LOOP_SHIFT;
  endfunction

  function automatic void open_shift();
    sclk_phase = 1'b1;
    pulse_cnt  = '0;
    shift_acc  = '0;
  endfunction

  // Returns 1 on the tick the extra pulse after the data bits ends.
  function automatic logic clock_pulse(input logic din);
    if (!sclk_phase) begin
      sclk_phase = 1'b1;
      return 1'b0;
    end
    sclk_phase = 1'b0;
    if (pulse_cnt < SAMPLE_BITS) begin
      shift_acc = {shift_acc[SAMPLE_BITS-2:0], din};
    end
    pulse_cnt = pulse_cnt + 1'b1;
    return pulse_cnt >= SAMPLE_BITS + 1;
  endfunction

  function automatic out_t scale_step(input in_t tick);
    out_t res;
    logic ms_tick;
    res     = '0;
    ms_tick = 1'b0;
    if (lid_phase(scale_mode)) begin
      if (int'(ms_presc) + 1 >= int'(TICKS_PER_MS)) begin
        ms_presc = '0;
        ms_tick  = 1'b1;
      end else begin
        ms_presc = ms_presc + 1'b1;
      end
      if (ms_tick && elapsed_ms != '1) begin
        elapsed_ms = elapsed_ms + 1'b1;
      end
    end
    case (scale_mode)
      MODE_IDLE, MODE_REACHED, MODE_TIMEDOUT: begin
        if (tick.start_req) begin
          scale_mode = MODE_FIRST_WAIT;
          sclk_phase = 1'b0;
        end
      end
      MODE_FIRST_WAIT: begin
        if (!tick.data_pin) begin
          open_shift();
          scale_mode = MODE_FIRST_SHIFT;
        end
      end
      MODE_FIRST_SHIFT: begin
        if (clock_pulse(tick.data_pin)) begin
          last_weight  = shift_acc;
          prior_weight = shift_acc;
          ms_presc     = '0;
          elapsed_ms   = '0;
          waited_ms    = '0;
          if ($signed(last_weight) >= tgt_weight) begin
            scale_mode = MODE_REACHED;
          end else begin
            scale_mode = MODE_DELAY;
          end
        end
      end
      MODE_DELAY: begin
        if (ms_tick && waited_ms != '1) begin
          waited_ms = waited_ms + 1'b1;
        end
        if (waited_ms >= period_ms) begin
          scale_mode = MODE_LOOP_WAIT;
        end
      end
      MODE_LOOP_WAIT: begin
        if (!tick.data_pin) begin
          open_shift();
          scale_mode = MODE_LOOP_SHIFT;
        end
      end
      default: begin
        if (clock_pulse(tick.data_pin)) begin
          last_weight      = shift_acc;
          res.sample_valid = 1'b1;
          res.stable       = $signed(last_weight) <= $signed(prior_weight);
          prior_weight     = last_weight;
          weighings++;
          if (elapsed_ms > abort_ms) begin
            scale_mode = MODE_TIMEDOUT;
          end else if ($signed(last_weight) >= tgt_weight) begin
            scale_mode = MODE_REACHED;
          end else begin
            waited_ms  = '0;
            scale_mode = MODE_DELAY;
          end
        end
      end
    endcase
    case (scale_mode)
      MODE_IDLE:     res.status = STATUS_IDLE;
      MODE_REACHED:  res.status = STATUS_REACHED;
      MODE_TIMEDOUT: res.status = STATUS_TIMEDOUT;
      default:       res.status = STATUS_BUSY;
    endcase
    res.lid_open     = lid_phase(scale_mode);
    res.serial_clock = sclk_phase;
    res.weight       = last_weight;
    return res;
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > WEIGHT_MAX) return WEIGHT_MAX;
    if (v < WEIGHT_MIN) return WEIGHT_MIN;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic send_tick(input logic start, input logic din);
    in_t         tick;
    int unsigned gap;
    tick.start_req = start;
    tick.data_pin  = din;
    in_valid_i <= 1'b1;
    in_data_i  <= tick;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (scale_mode != MODE_DELAY) live_ticks++;
    pending_readings.push_back(scale_step(tick));
    if (burst_left > 0) burst_left--;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(1, 200);
      gap        = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TARGET:  tgt_weight = data;
      CFG_PERIOD:  period_ms  = data[MS_W-1:0];
      CFG_TIMEOUT: abort_ms   = data[MS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [2:0] which, input longint tgt,
                           input logic [MS_W-1:0] per, input logic [MS_W-1:0] tmo);
    if (which[0]) write_reg(CFG_TARGET, CFG_DATA_W'(tgt));
    if (which[1]) write_reg(CFG_PERIOD, CFG_DATA_W'(per));
    if (which[2]) write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic weigh(input logic [SAMPLE_BITS-1:0] value, input int unsigned hold_high);
    logic din;
    while (scale_mode inside {MODE_FIRST_WAIT, MODE_FIRST_SHIFT,
                              MODE_LOOP_WAIT, MODE_LOOP_SHIFT}) begin
      if (scale_mode == MODE_FIRST_WAIT || scale_mode == MODE_LOOP_WAIT) begin
        din = hold_high != 0;
        if (hold_high != 0) hold_high--;
      end else if (sclk_phase && pulse_cnt < SAMPLE_BITS) begin
        din = value[SAMPLE_BITS - 1 - int'(pulse_cnt)];
      end else begin
        din = 1'($urandom_range(0, 1));
      end
      send_tick(1'($urandom_range(0, 1)), din);
    end
  endtask

  task automatic pass_delay();
    while (scale_mode == MODE_DELAY) begin
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_fill(input longint first_w, input longint stride,
                          input int unsigned max_reads, input bit retarget);
    longint      w;
    int unsigned reads;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    weigh(SAMPLE_BITS'(first_w), $urandom_range(0, 4));
    w     = first_w;
    reads = 0;
    while (scale_mode == MODE_DELAY) begin
      if (retarget && $urandom_range(0, 3) == 0) begin
        settle();
        configure(3'b011, clamp24(w + longint'($urandom_range(0, 2 * int'(stride)))),
                  MS_W'($urandom_range(0, 2)), '0);
      end
      pass_delay();
      reads++;
      if (reads >= max_reads) begin
        w = WEIGHT_MAX;
      end else begin
        case ($urandom_range(0, 5))
          0:       w = w - longint'($urandom_range(0, 50));
          1:       w = w;
          default: w = w + stride + longint'($urandom_range(0, int'(stride / 2) + 1));
        endcase
        w = clamp24(w);
      end
      weigh(SAMPLE_BITS'(w), $urandom_range(0, 3));
    end
  endtask

  task automatic test_reset_idle();
    repeat (4) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_first_sample_reached();
    send_tick(1'b1, 1'b1);
    weigh(SAMPLE_BITS'(300), 20);
    repeat (3) send_tick(1'b0, 1'b0);
  endtask

  task automatic test_register_extremes();
    settle();
    configure(3'b111, WEIGHT_MIN, '1, '1);
    send_tick(1'b1, 1'b0);
    weigh(SAMPLE_BITS'(WEIGHT_MIN), 0);
    settle();
    configure(3'b001, WEIGHT_MAX, '0, '0);
    send_tick(1'b1, 1'b1);
    weigh(SAMPLE_BITS'(WEIGHT_MAX), 1);
  endtask

  task automatic test_timeout_abort();
    settle();
    configure(3'b111, WEIGHT_MAX, MS_W'(1), '0);
    send_tick(1'b1, 1'b0);
    weigh(SAMPLE_BITS'(-5), 0);
    pass_delay();
    weigh(SAMPLE_BITS'(-9), 2);
    settle();
    configure(3'b100, WEIGHT_MAX, MS_W'(1), MS_W'(2));
    run_fill(-100, 10, 50, 1'b0);
  endtask

  task automatic test_zero_period();
    settle();
    configure(3'b111, 1000, '0, '1);
    run_fill(0, 300, 8, 1'b0);
  endtask

  task automatic test_retarget_mid_fill();
    settle();
    configure(3'b111, WEIGHT_MAX, MS_W'(1), '1);
    send_tick(1'b1, 1'b0);
    weigh(SAMPLE_BITS'(100), 0);
    settle();
    configure(3'b011, 150, '0, '0);
    pass_delay();
    weigh(SAMPLE_BITS'(200), 0);
  endtask

  task automatic test_output_hold_off();
    settle();
    configure(3'b111, 5000, MS_W'(1), '1);
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    run_fill(0, 1500, 6, 1'b0);
    settle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_fills();
    int unsigned goal_samples;
    int unsigned goal_live;
    longint      first_w;
    longint      offset;
    longint      stride;
    logic [MS_W-1:0] per;
    logic [MS_W-1:0] tmo;
    goal_samples = weighings + 40;
    goal_live    = live_ticks + 500;
    while (weighings < goal_samples || live_ticks < goal_live) begin
      case ($urandom_range(0, 7))
        0:       first_w = longint'($urandom_range(0, 16777215)) + WEIGHT_MIN;
        1:       first_w = WEIGHT_MIN;
        2:       first_w = WEIGHT_MAX;
        default: first_w = longint'($urandom_range(0, 10000)) - 5000;
      endcase
      offset = longint'($urandom_range(0, 4000)) - 200;
      stride = offset / longint'($urandom_range(1, 4));
      if (stride < 1) stride = 1;
      case ($urandom_range(0, 5))
        0:       per = '0;
        4:       per = MS_W'(2);
        5:       per = MS_W'(3);
        default: per = MS_W'(1);
      endcase
      case ($urandom_range(0, 7))
        0:       tmo = '0;
        1:       tmo = MS_W'(1);
        2:       tmo = MS_W'(2);
        3:       tmo = MS_W'(4);
        default: tmo = '1;
      endcase
      settle();
      configure(3'($urandom_range(1, 7)), clamp24(first_w + offset), per, tmo);
      gaps_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
      run_fill(first_w, stride, $urandom_range(2, 6), $urandom_range(0, 5) == 0);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_seg == 0) begin
        stall_seg = $urandom_range(1, 80);
        case ($urandom_range(0, 4))
          2:       stall_pct = 20;
          3:       stall_pct = 50;
          4:       stall_pct = 85;
          default: stall_pct = 0;
        endcase
      end
      stall_seg--;
      out_stall_i <= $urandom_range(0, 99) < stall_pct;
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result, weight", 0, out_data_o.weight);
      end else begin
        want = pending_readings.pop_front();
        if (out_data_o.serial_clock !== want.serial_clock)
          report_mismatch("serial_clock", want.serial_clock, out_data_o.serial_clock);
        if (out_data_o.lid_open !== want.lid_open)
          report_mismatch("lid_open", want.lid_open, out_data_o.lid_open);
        if (out_data_o.weight !== want.weight)
          report_mismatch("weight", want.weight, out_data_o.weight);
        if (out_data_o.sample_valid !== want.sample_valid)
          report_mismatch("sample_valid", want.sample_valid, out_data_o.sample_valid);
        if (out_data_o.stable !== want.stable)
          report_mismatch("stable", want.stable, out_data_o.stable);
        if (out_data_o.status !== want.status)
          report_mismatch("status", want.status, out_data_o.status);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("load_cell_fill_to_weight_controller_tb: errors");
      $finish;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    out_stall_i  <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= CFG_TARGET;
    cfg_data_i   <= '0;
    scale_mode   = MODE_IDLE;
    shift_acc    = '0;
    last_weight  = '0;
    prior_weight = '0;
    pulse_cnt    = '0;
    sclk_phase   = 1'b0;
    ms_presc     = '0;
    elapsed_ms   = '0;
    waited_ms    = '0;
    tgt_weight   = TARGET_RESET;
    period_ms    = PERIOD_RESET;
    abort_ms     = TIMEOUT_RESET;
    mismatches   = 0;
    weighings    = 0;
    live_ticks   = 0;
    cycle_count  = 0;
    burst_left   = 0;
    gaps_on      = 1'b1;
    hold_off_req = 1'b0;
    hold_left    = 0;
    stall_seg    = 0;
    stall_pct    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_idle();
    test_first_sample_reached();
    test_register_extremes();
    test_timeout_abort();
    test_zero_period();
    test_retarget_mid_fill();
    test_output_hold_off();
    test_random_fills();

    settle();
    if (mismatches == 0) begin
      $display("load_cell_fill_to_weight_controller_tb: clean");
    end else begin
      $display("load_cell_fill_to_weight_controller_tb: errors");
    end
    $finish;
  end

endmodule

@@ load_cell_fill_to_weight_controller.f @@
+incdir+hdl
hdl/lcfw_pkg.sv
hdl/lcfw_core.sv
hdl/lcfw_outbuf.sv
hdl/load_cell_fill_to_weight_controller.sv
sim/load_cell_fill_to_weight_controller_tb.sv
